@@ rtl/core/spq_pkg.sv @@
package spq_pkg;

    // Number of slots in the queue and the field widths of one slot.
    localparam int CAPACITY = 16;
    localparam int PRIO_W   = 8;
    localparam int ID_W     = 8;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_SERVE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // What every cell of the row does with its slot.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_SHIFT  = 2'd3
    } cell_op_t;

    typedef enum logic {
        PH_IDLE   = 1'b0,
        PH_INSERT = 1'b1
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } slot_t;

    typedef struct packed {
        cell_op_t          op;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } cell_cmd_t;

endpackage

@@ rtl/core/spq_cell.sv @@
module spq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::cell_cmd_t cmd,
    input  spq_pkg::slot_t     left_slot,
    input  logic               left_keep,
    input  logic               found_in,
    input  spq_pkg::slot_t     right_slot,
    output spq_pkg::slot_t     slot,
    output logic               keep,
    output logic               found_out
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [spq_pkg::ID_W-1:0]   id_reg;
    logic [spq_pkg::ID_W-1:0]   id_next;
    logic [spq_pkg::PRIO_W-1:0] prio_reg;
    logic [spq_pkg::PRIO_W-1:0] prio_next;
    logic                       match;

    assign slot      = '{valid: valid_reg, id: id_reg, prio: prio_reg};
    assign match     = valid_reg && (id_reg == cmd.id);
    assign found_out = found_in | match;
    // An entry of equal or higher priority stays ahead of a new one.
    assign keep      = valid_reg && (prio_reg >= cmd.prio);

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        unique case (cmd.op)
            spq_pkg::CELL_HOLD:
            begin
            end
            spq_pkg::CELL_INSERT:
            begin
                if (!keep)
                begin
                    if (left_keep)
                    begin
                        valid_next = 1'b1;
                        id_next    = cmd.id;
                        prio_next  = cmd.prio;
                    end
                    else
                    begin
                        valid_next = left_slot.valid;
                        id_next    = left_slot.id;
                        prio_next  = left_slot.prio;
                    end
                end
            end
            spq_pkg::CELL_REMOVE:
            begin
                if (found_out)
                begin
                    valid_next = right_slot.valid;
                    id_next    = right_slot.id;
                    prio_next  = right_slot.prio;
                end
            end
            spq_pkg::CELL_SHIFT:
            begin
                valid_next = right_slot.valid;
                id_next    = right_slot.id;
                prio_next  = right_slot.prio;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

endmodule

@@ rtl/core/sorted_priority_queue_top.sv @@
// Sorted priority queue of up to CAPACITY entries, highest priority at the head and
// first-come first-served among equal priorities.
// A request is taken at a rising edge where start is high and busy is low; it carries
// action, entry_id and priority_req. Exactly one result follows for every request: done
// is high for one cycle with served_id, served_valid, status and occupancy on the
// result ports, and the receiver must take it in that cycle, as it cannot stall.
// Add, remove and serve return their result strobe in the cycle after the request is
// taken, and a new request may be given in that same cycle.
// Update pulls any old entry out and inserts the id with its new priority in its insert
// phase, so busy is high for one cycle and the result strobe follows that phase.
// The sustained rate is therefore one request per cycle while no update holds busy,
// set by the single shift step that each cell makes per cycle.
// The entries live in a row of cells, each holding one slot and passing it to its left
// or right neighbour when a request opens or closes a gap.
// Reset empties the queue at once: every cell is marked invalid and no clearing pass is
// needed, so a request may be given in the first cycle after reset is released.
module sorted_priority_queue_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 action,
    input  logic [spq_pkg::ID_W-1:0]   entry_id,
    input  logic [7:0]                 priority_req,
    output logic                       done,
    output logic [spq_pkg::ID_W-1:0]   served_id,
    output logic                       served_valid,
    output logic [1:0]                 status,
    output logic [4:0]                 occupancy
);

    // Control registers.
    spq_pkg::phase_t                phase_reg;
    spq_pkg::phase_t                phase_next;
    logic [spq_pkg::COUNT_W-1:0]    count_reg;
    logic [spq_pkg::COUNT_W-1:0]    count_next;
    logic                           done_reg;
    logic                           done_next;

    // The pending update request, held for its insert cycle.
    logic [spq_pkg::ID_W-1:0]       pend_id_reg;
    logic [spq_pkg::ID_W-1:0]       pend_id_next;
    logic [spq_pkg::PRIO_W-1:0]     pend_prio_reg;
    logic [spq_pkg::PRIO_W-1:0]     pend_prio_next;

    // Result registers.
    logic [spq_pkg::ID_W-1:0]       served_id_reg;
    logic [spq_pkg::ID_W-1:0]       served_id_next;
    logic                           served_valid_reg;
    logic                           served_valid_next;
    spq_pkg::status_t               status_reg;
    spq_pkg::status_t               status_next;
    logic [spq_pkg::COUNT_W-1:0]    occupancy_reg;

    logic                           accept;
    logic                           full;
    logic                           found;
    spq_pkg::action_t               act;
    logic [spq_pkg::PRIO_W-1:0]     req_prio;
    spq_pkg::cell_cmd_t             cmd;

    // Row of cells and the signals that run along it.
    spq_pkg::slot_t                 cell_slot [spq_pkg::CAPACITY];
    logic [spq_pkg::CAPACITY-1:0]   keep_vec;
    logic [spq_pkg::CAPACITY-1:0]   found_vec;
    logic [spq_pkg::CAPACITY-1:0]   valid_vec;

    assign busy     = (phase_reg == spq_pkg::PH_INSERT);
    assign accept   = start && !busy;
    assign act      = spq_pkg::action_t'(action);
    assign req_prio = priority_req[spq_pkg::PRIO_W-1:0];
    assign full     = (count_reg == spq_pkg::COUNT_W'(spq_pkg::CAPACITY));
    // The search chain leaves the last cell set when any slot held the id.
    assign found    = found_vec[spq_pkg::CAPACITY-1];

    // Next phase: an accepted update moves on to its insert phase.
    always_comb
    begin
        phase_next = spq_pkg::PH_IDLE;
        if (phase_reg == spq_pkg::PH_IDLE && accept && act == spq_pkg::ACT_UPDATE)
        begin
            phase_next = spq_pkg::PH_INSERT;
        end
    end

    // Command to the row. It depends only on the request and the registers, never on
    // the search result that the row hands back.
    always_comb
    begin
        cmd = '{op: spq_pkg::CELL_HOLD, id: entry_id, prio: req_prio};
        if (phase_reg == spq_pkg::PH_INSERT)
        begin
            cmd.id   = pend_id_reg;
            cmd.prio = pend_prio_reg;
            if (!full)
            begin
                cmd.op = spq_pkg::CELL_INSERT;
            end
        end
        else if (accept)
        begin
            unique case (act)
                spq_pkg::ACT_ADD:
                begin
                    if (!full)
                    begin
                        cmd.op = spq_pkg::CELL_INSERT;
                    end
                end
                spq_pkg::ACT_REMOVE, spq_pkg::ACT_UPDATE:
                begin
                    cmd.op = spq_pkg::CELL_REMOVE;
                end
                spq_pkg::ACT_SERVE:
                begin
                    if (count_reg != '0)
                    begin
                        cmd.op = spq_pkg::CELL_SHIFT;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // The new occupancy and the result of this cycle.
    always_comb
    begin
        count_next        = count_reg;
        done_next         = 1'b0;
        served_id_next    = '0;
        served_valid_next = 1'b0;
        status_next       = spq_pkg::ST_OK;
        pend_id_next      = pend_id_reg;
        pend_prio_next    = pend_prio_reg;
        if (phase_reg == spq_pkg::PH_INSERT)
        begin
            done_next = 1'b1;
            if (full)
            begin
                status_next = spq_pkg::ST_FULL;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (accept)
        begin
            unique case (act)
                spq_pkg::ACT_ADD:
                begin
                    done_next = 1'b1;
                    if (full)
                    begin
                        status_next = spq_pkg::ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                spq_pkg::ACT_REMOVE:
                begin
                    done_next = 1'b1;
                    if (found)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        status_next = spq_pkg::ST_NOT_FOUND;
                    end
                end
                spq_pkg::ACT_UPDATE:
                begin
                    // Pull the old entry out now; the insert follows next cycle.
                    pend_id_next   = entry_id;
                    pend_prio_next = req_prio;
                    if (found)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                spq_pkg::ACT_SERVE:
                begin
                    done_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        status_next = spq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        served_id_next    = cell_slot[0].id;
                        served_valid_next = 1'b1;
                        count_next        = count_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    generate
        for (genvar i = 0; i < spq_pkg::CAPACITY; i++)
        begin : g_cell
            spq_pkg::slot_t left_slot;
            spq_pkg::slot_t right_slot;
            logic           left_keep;
            logic           found_in;

            if (i == 0)
            begin : g_head
                // The head cell sees an empty slot to its left that always stays put.
                assign left_slot = '0;
                assign left_keep = 1'b1;
                assign found_in  = 1'b0;
            end
            else
            begin : g_body
                assign left_slot = cell_slot[i-1];
                assign left_keep = keep_vec[i-1];
                assign found_in  = found_vec[i-1];
            end

            if (i == spq_pkg::CAPACITY - 1)
            begin : g_tail
                assign right_slot = '0;
            end
            else
            begin : g_inner
                assign right_slot = cell_slot[i+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .left_slot  (left_slot),
                .left_keep  (left_keep),
                .found_in   (found_in),
                .right_slot (right_slot),
                .slot       (cell_slot[i]),
                .keep       (keep_vec[i]),
                .found_out  (found_vec[i])
            );

            assign valid_vec[i] = cell_slot[i].valid;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= spq_pkg::PH_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg      <= pend_id_next;
        pend_prio_reg    <= pend_prio_next;
        served_id_reg    <= served_id_next;
        served_valid_reg <= served_valid_next;
        status_reg       <= status_next;
        occupancy_reg    <= count_next;
    end

    assign done         = done_reg;
    assign served_id    = served_id_reg;
    assign served_valid = served_valid_reg;
    assign status       = status_reg;
    assign occupancy    = 5'(occupancy_reg);

`ifndef SYNTH
    // The occupancy count always matches the number of valid cells.
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(count_reg))
        else $error("occupancy count disagrees with the valid cells");

    // The count never passes the capacity of the row.
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= spq_pkg::COUNT_W'(spq_pkg::CAPACITY))
        else $error("occupancy count beyond capacity");

    // An accepted update request always spends one busy cycle on its insert.
    a_update_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && act == spq_pkg::ACT_UPDATE) |=> busy)
        else $error("update request did not enter its insert cycle");

    // The insert cycle lasts exactly one cycle and ends with a result.
    a_insert_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (!busy && done))
        else $error("insert cycle did not finish in one cycle");

    // A served entry always reports success.
    a_served_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && served_valid) |-> (status == spq_pkg::ST_OK))
        else $error("served entry with a failure status");
`endif

endmodule
